/* rtl/dkw_pkg.sv */
// ----------------------------------------------------------------------------
// dkw_pkg
// shared codes, constants, types and helper functions of the defocus kernel
// weight block
// ----------------------------------------------------------------------------
package dkw_pkg;

    // kernel shape codes
    localparam logic [2:0] MODEL_FLAT    = 3'd0;
    localparam logic [2:0] MODEL_SPHERE  = 3'd1;
    localparam logic [2:0] MODEL_GAUSS   = 3'd2;
    localparam logic [2:0] MODEL_RING    = 3'd3;
    localparam logic [2:0] MODEL_CONCAVE = 3'd4;

    // register indexes on the config port
    localparam logic [1:0] REG_MODEL = 2'd0;
    localparam logic [1:0] REG_FILL  = 2'd1;
    localparam logic [1:0] REG_GAUSS = 2'd2;

    localparam logic [15:0] ONE_Q15    = 16'd32768;
    localparam logic [16:0] LOG2E_Q16  = 17'd94548;
    localparam logic [15:0] LN2_Q16    = 16'd45426;
    // ceil(2^32 / 100), exact floor division for numerators below 2^22
    localparam logic [25:0] RECIP_100  = 26'd42949673;

    // quotient widths of the two divider flavors
    localparam int SPH_Q_W   = 16;
    localparam int GAUSS_Q_W = 21;

    // side info that rides along the long pipeline
    typedef struct packed {
        logic [15:0] wbase;
        logic        dz;
        logic        inner;
        logic        sph_zero;
        logic        far_zero;
        logic        gcut;
        logic        szero;
        logic        cblend;
        logic [8:0]  wd;
    } t_side;

    // 2^(-k/16) in Q.16
    function automatic logic [16:0] exp2_frac(input logic [3:0] k);
        logic [16:0] v;
        case (k)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd62757;
            4'd2:    v = 17'd60097;
            4'd3:    v = 17'd57549;
            4'd4:    v = 17'd55109;
            4'd5:    v = 17'd52773;
            4'd6:    v = 17'd50535;
            4'd7:    v = 17'd48393;
            4'd8:    v = 17'd46341;
            4'd9:    v = 17'd44376;
            4'd10:   v = 17'd42495;
            4'd11:   v = 17'd40693;
            4'd12:   v = 17'd38968;
            4'd13:   v = 17'd37316;
            4'd14:   v = 17'd35734;
            default: v = 17'd34219;
        endcase
        return v;
    endfunction

    // f + t*(1-f), clamped to one
    function automatic logic [15:0] fill_blend(input logic [15:0] t, input logic [15:0] f);
        logic [31:0] prod;
        logic [16:0] sum;
        prod = 32'(t) * 32'(ONE_Q15 - f);
        sum  = 17'(f) + prod[31:15];
        return (sum > 17'(ONE_Q15)) ? ONE_Q15 : sum[15:0];
    endfunction

endpackage

/* rtl/dkw_div.sv */
// ----------------------------------------------------------------------------
// dkw_div
// pipelined restoring divider, one quotient bit per stage plus an overflow
// stage in front
// ----------------------------------------------------------------------------
module dkw_div #(
    parameter int NUM_W = 32,
    parameter int DEN_W = 17,
    parameter int Q_W   = 16
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo,
    output logic             o_ovf
);

    localparam int CW = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

    logic [NUM_W-1:0] r_rem [0:Q_W];
    logic [DEN_W-1:0] r_den [0:Q_W];
    logic [Q_W-1:0]   r_quo [0:Q_W];
    logic [Q_W:0]     r_ovf;

    logic [CW-1:0] w_lim;
    assign w_lim = CW'(i_den) << Q_W;

    // quotient too large for Q_W bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= i_num;
            r_den[0] <= i_den;
            r_quo[0] <= '0;
            r_ovf[0] <= (CW'(i_num) >= w_lim);
        end
    end

    for (genvar s = 1; s <= Q_W; s++) begin : g_stage
        localparam int BI = Q_W - s;
        logic [CW-1:0] w_cand;
        logic          w_take;
        assign w_cand = CW'(r_den[s-1]) << BI;
        assign w_take = CW'(r_rem[s-1]) >= w_cand;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s] <= r_den[s-1];
                r_ovf[s] <= r_ovf[s-1];
                if (w_take) begin
                    r_rem[s] <= r_rem[s-1] - NUM_W'(w_cand);
                    r_quo[s] <= r_quo[s-1] | (Q_W'(1) << BI);
                end else begin
                    r_rem[s] <= r_rem[s-1];
                    r_quo[s] <= r_quo[s-1];
                end
            end
        end
    end

    assign o_quo = r_quo[Q_W];
    assign o_ovf = r_ovf[Q_W];

endmodule

/* rtl/dkw_sqrt.sv */
// ----------------------------------------------------------------------------
// dkw_sqrt
// pipelined integer square root of a value up to 2^30, one result bit per
// stage
// ----------------------------------------------------------------------------
module dkw_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_arg,
    output logic [15:0] o_root
);

    localparam int STEPS = 16;

    logic [30:0] r_v   [0:STEPS-1];
    logic [31:0] r_res [0:STEPS-1];

    for (genvar j = 0; j < STEPS; j++) begin : g_step
        localparam logic [31:0] BIT = 32'd1 << (30 - 2 * j);
        logic [30:0] w_vin;
        logic [31:0] w_rin;
        logic [31:0] w_sum;
        logic        w_take;
        if (j == 0) begin : g_first
            assign w_vin = i_arg;
            assign w_rin = '0;
        end else begin : g_next
            assign w_vin = r_v[j-1];
            assign w_rin = r_res[j-1];
        end
        assign w_sum  = w_rin + BIT;
        assign w_take = {1'b0, w_vin} >= w_sum;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (w_take) begin
                    r_v[j]   <= w_vin - w_sum[30:0];
                    r_res[j] <= (w_rin >> 1) + BIT;
                end else begin
                    r_v[j]   <= w_vin;
                    r_res[j] <= w_rin >> 1;
                end
            end
        end
    end

    assign o_root = r_res[STEPS-1][15:0];

endmodule

/* rtl/dkw_delay.sv */
// ----------------------------------------------------------------------------
// dkw_delay
// enabled shift register that keeps side data in step with the pipeline
// ----------------------------------------------------------------------------
module dkw_delay #(
    parameter int W = 16,
    parameter int N = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sh [0:N-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh[0] <= i_d;
            for (int i = 1; i < N; i++) begin
                r_sh[i] <= r_sh[i-1];
            end
        end
    end

    assign o_q = r_sh[N-1];

endmodule

/* rtl/defocus_kernel_weight.sv */
// ----------------------------------------------------------------------------
// defocus_kernel_weight
// unnormalized defocus kernel weight for flat, spherical, gaussian, ring and
// concave shapes, Q1.15 clamped to one
// ----------------------------------------------------------------------------
// depth: the spherical path is the longest (input stage, 17-stage divider,
//   one square stage, 16-stage square root)
// throughput: one request per cycle while the 2-entry output buffer is not
//   full or i_ready is high, so requests keep flowing while a result waits
// reset: synchronous active low; clears valids, buffer and registers
//   (model flat, fill 0, gauss factor 1.0)
module defocus_kernel_weight
    import dkw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_blur_radius,
    input  logic [15:0] i_tap_distance,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_weight,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int LAST = 35;

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    logic [2:0]  r_model;
    logic [6:0]  r_fill;
    logic [15:0] r_gauss;
    logic [15:0] r_fill_q15;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model <= MODEL_FLAT;
            r_fill  <= '0;
            r_gauss <= 16'd4096;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_MODEL: r_model <= pwdata[2:0];
                REG_FILL:  r_fill  <= pwdata[6:0];
                REG_GAUSS: r_gauss <= pwdata[15:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MODEL: prdata = {29'd0, r_model};
            REG_FILL:  prdata = {25'd0, r_fill};
            REG_GAUSS: prdata = {16'd0, r_gauss};
            default:   prdata = '0;
        endcase
    end

    // fill level in Q1.15, rounded percent, by reciprocal multiply
    logic [6:0]  w_fpc;
    logic [21:0] w_fnum;
    logic [47:0] w_fprod;
    assign w_fpc   = (r_fill > 7'd100) ? 7'd100 : r_fill;
    assign w_fnum  = {w_fpc, 15'd0} + 22'd50;
    assign w_fprod = 48'(w_fnum) * 48'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_q15 <= '0;
        end else begin
            r_fill_q15 <= w_fprod[47:32];
        end
    end

    // ------------------------------------------------------------------
    // flow control: whole pipeline moves together, output buffer of two
    // ------------------------------------------------------------------
    logic         en;
    logic [LAST:1] r_vld;
    logic [1:0]   r_cnt;
    logic         r_wp;
    logic         r_rp;
    logic [15:0]  r_buf [0:1];
    logic         w_push;
    logic         w_pop;
    logic [15:0]  w_final;

    // advance unless the buffer is full and nothing drains this cycle
    assign en      = (r_cnt != 2'd2) || i_ready;
    assign o_ready = en;
    assign w_push  = en && r_vld[LAST];
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:1], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // stage 1: offsets, compares, sigma product
    // ------------------------------------------------------------------
    logic [16:0]        w_rr;
    logic [16:0]        w_fdraw;
    logic               w_farz;
    logic [16:0]        w_fd;
    logic [15:0]        w_nd;
    logic               w_small;
    logic               w_sphz;
    logic [16:0]        w_wdf;
    logic [16:0]        w_r256;
    logic [32:0]        w_gp;
    logic signed [17:0] w_d;

    assign w_rr    = {1'b0, i_blur_radius} + 17'd128;
    assign w_fdraw = {1'b0, i_tap_distance} + 17'd128;
    assign w_farz  = w_fdraw > w_rr;
    assign w_fd    = w_farz ? w_rr : w_fdraw;
    assign w_nd    = i_tap_distance - 16'd128;
    assign w_small = i_tap_distance < 16'd128;
    assign w_sphz  = !w_small && ({1'b0, w_nd} > w_rr);
    assign w_wdf   = w_fd - {1'b0, w_nd};
    assign w_r256  = {1'b0, i_blur_radius} + 17'd256;
    assign w_gp    = 33'(r_gauss) * 33'(w_r256);
    assign w_d     = $signed({2'b00, i_blur_radius}) + 18'sd256
                     - $signed({2'b00, i_tap_distance});

    logic [15:0]        r1_r;
    logic [15:0]        r1_d;
    logic [16:0]        r1_rr;
    logic [16:0]        r1_fd;
    logic [15:0]        r1_nd;
    logic               r1_small;
    logic               r1_sphz;
    logic               r1_farz;
    logic [8:0]         r1_wd;
    logic [32:0]        r1_gp;
    logic               r1_gcut;
    logic signed [17:0] r1_dd;
    logic               r1_dz;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_r     <= i_blur_radius;
            r1_d     <= i_tap_distance;
            r1_rr    <= w_rr;
            r1_fd    <= w_fd;
            r1_nd    <= w_nd;
            r1_small <= w_small;
            r1_sphz  <= w_sphz;
            r1_farz  <= w_farz;
            r1_wd    <= w_wdf[8:0];
            r1_gp    <= w_gp;
            r1_gcut  <= {1'b0, i_tap_distance} >= w_r256;
            r1_dd    <= w_d;
            r1_dz    <= (i_tap_distance == 16'd0);
        end
    end

    // ------------------------------------------------------------------
    // stage 2: sigma squared, distance squared, direct weights
    // ------------------------------------------------------------------
    logic [24:0] w_s;
    logic        w_dle0;
    logic [15:0] w_lin;
    logic [15:0] w_center;
    logic signed [17:0] w_rdiff;
    logic [15:0] w_rbl;
    logic [15:0] w_wbase;
    logic        w_cblend;

    assign w_s      = r1_gp[32:8];
    assign w_dle0   = (r1_dd <= 18'sd0);
    assign w_lin    = {r1_dd[8:0], 7'd0};
    // center tap: full weight up to radius 5, fill level beyond
    assign w_center = (r1_r <= 16'd1280) ? ONE_Q15 : r_fill_q15;
    assign w_rdiff  = 18'sd512 - r1_dd;
    assign w_rbl    = fill_blend({1'b0, w_rdiff[7:0], 7'd0}, r_fill_q15);
    // concave edge ramp comes later from the shared divider
    assign w_cblend = (r_model == MODEL_CONCAVE) && !r1_dz && (r1_dd > 18'sd256);

    always_comb begin
        case (r_model)
            MODEL_FLAT: begin
                if (w_dle0)                  w_wbase = '0;
                else if (r1_dd >= 18'sd256)  w_wbase = ONE_Q15;
                else                         w_wbase = w_lin;
            end
            MODEL_RING: begin
                if (r1_dz)                   w_wbase = w_center;
                else if (w_dle0)             w_wbase = '0;
                else if (r1_dd >= 18'sd512)  w_wbase = r_fill_q15;
                else if (r1_dd > 18'sd256)   w_wbase = w_rbl;
                else                         w_wbase = w_lin;
            end
            MODEL_CONCAVE: begin
                if (r1_dz)                   w_wbase = w_center;
                else if (w_dle0)             w_wbase = '0;
                else if (r1_dd > 18'sd256)   w_wbase = '0;
                else                         w_wbase = w_lin;
            end
            default:                         w_wbase = '0;
        endcase
    end

    logic [49:0] r2_ss;
    logic [31:0] r2_dsq;
    t_side       r2_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_ss            <= 50'(w_s) * 50'(w_s);
            r2_dsq           <= 32'(r1_d) * 32'(r1_d);
            r2_side.wbase    <= w_wbase;
            r2_side.dz       <= r1_dz;
            r2_side.inner    <= r1_small;
            r2_side.sph_zero <= r1_sphz;
            r2_side.far_zero <= r1_farz;
            r2_side.gcut     <= r1_gcut;
            r2_side.szero    <= (w_s == 25'd0);
            r2_side.cblend   <= w_cblend;
            r2_side.wd       <= r1_wd;
        end
    end

    // ------------------------------------------------------------------
    // spherical / concave: ratio x/r for the far and near edges
    // ------------------------------------------------------------------
    logic [SPH_Q_W-1:0] w_tf;
    logic [SPH_Q_W-1:0] w_tn;
    logic               w_ovf_f;
    logic               w_ovf_n;

    dkw_div #(.NUM_W(32), .DEN_W(17), .Q_W(SPH_Q_W)) u_div_far (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r1_fd, 15'd0}),
        .i_den (r1_rr),
        .o_quo (w_tf),
        .o_ovf (w_ovf_f)
    );

    dkw_div #(.NUM_W(32), .DEN_W(17), .Q_W(SPH_Q_W)) u_div_near (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({1'b0, r1_nd, 15'd0}),
        .i_den (r1_rr),
        .o_quo (w_tn),
        .o_ovf (w_ovf_n)
    );

    // ratios never exceed one on the paths that use them
    logic [31:0] w_tf2;
    logic [31:0] w_tn2;
    assign w_tf2 = 32'(w_tf) * 32'(w_tf);
    assign w_tn2 = 32'(w_tn) * 32'(w_tn);

    logic [30:0] r19_af;
    logic [30:0] r19_an;
    logic [15:0] r19_q;
    logic [15:0] r20_cb;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r19_af <= 31'(32'h4000_0000 - w_tf2);
            // near ratio overflows once the near offset reaches twice the radius plus half a pixel
            r19_an <= w_ovf_n ? 31'd0 : 31'(32'h4000_0000 - w_tn2);
            // concave ramp uses the far ratio alone
            r19_q  <= w_ovf_f ? 16'd0 : w_tf2[30:15];
            r20_cb <= fill_blend(r19_q, r_fill_q15);
        end
    end

    logic [15:0] w_far;
    logic [15:0] w_near;

    dkw_sqrt u_sqrt_far (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_arg  (r19_af),
        .o_root (w_far)
    );

    dkw_sqrt u_sqrt_near (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_arg  (r19_an),
        .o_root (w_near)
    );

    // ------------------------------------------------------------------
    // gaussian: exponent d^2 / (2 s^2), then 2^-y by table and polynomial
    // ------------------------------------------------------------------
    logic [GAUSS_Q_W-1:0] w_x;
    logic                 w_xovf;

    dkw_div #(.NUM_W(56), .DEN_W(51), .Q_W(GAUSS_Q_W)) u_div_gauss (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num ({r2_dsq, 24'd0}),
        .i_den ({r2_ss, 1'b0}),
        .o_quo (w_x),
        .o_ovf (w_xovf)
    );

    logic [37:0] w_y;
    logic [27:0] w_zp;
    logic [23:0] w_zz;
    logic [33:0] w_tp;
    logic [6:0]  w_n1;
    logic [16:0] w_sh;

    logic [21:0] r25_y;
    logic        r25_gz;
    logic [11:0] r26_z;
    logic [5:0]  r26_n;
    logic [3:0]  r26_k;
    logic        r26_gz;
    logic [16:0] r27_p;
    logic [5:0]  r27_n;
    logic [3:0]  r27_k;
    logic        r27_gz;
    logic [16:0] r28_v;
    logic [5:0]  r28_n;
    logic        r28_gz;
    logic [15:0] r29_gw;

    assign w_y  = 38'(w_x) * 38'(LOG2E_Q16);
    assign w_zp = 28'(r25_y[11:0]) * 28'(LN2_Q16);
    assign w_zz = 24'(r26_z) * 24'(r26_z);
    assign w_tp = 34'(exp2_frac(r27_k)) * 34'(r27_p);
    assign w_n1 = 7'(r28_n) + 7'd1;
    assign w_sh = r28_v >> w_n1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // x * log2(e)
            r25_y  <= w_y[37:16];
            r25_gz <= w_xovf;
            // fractional part as exponent of e
            r26_z  <= w_zp[27:16];
            r26_n  <= r25_y[21:16];
            r26_k  <= r25_y[15:12];
            r26_gz <= r25_gz;
            r27_p  <= 17'd65536 - 17'(r26_z) + 17'(w_zz[23:17]);
            r27_n  <= r26_n;
            r27_k  <= r26_k;
            r27_gz <= r26_gz;
            r28_v  <= w_tp[32:16];
            r28_n  <= r27_n;
            r28_gz <= r27_gz;
            // integer part of the exponent as a shift, extreme exponent gives zero
            if (r28_gz || (w_n1 >= 7'd32)) begin
                r29_gw <= '0;
            end else if (w_sh > 17'(ONE_Q15)) begin
                r29_gw <= ONE_Q15;
            end else begin
                r29_gw <= w_sh[15:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // line everything up at the last stage
    // ------------------------------------------------------------------
    logic [$bits(t_side)-1:0] w_side_bits;
    t_side                    w_side;
    logic [15:0]              w_gw;
    logic [15:0]              w_cb;

    dkw_delay #(.W($bits(t_side)), .N(LAST - 2)) u_dly_side (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r2_side),
        .o_q   (w_side_bits)
    );
    assign w_side = t_side'(w_side_bits);

    dkw_delay #(.W(16), .N(LAST - 29)) u_dly_gauss (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r29_gw),
        .o_q   (w_gw)
    );

    dkw_delay #(.W(16), .N(LAST - 20)) u_dly_concave (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (r20_cb),
        .o_q   (w_cb)
    );

    // trapezoid over the one-pixel annulus
    logic [16:0] w_ssum;
    logic [25:0] w_sp;
    assign w_ssum = 17'(w_near) + (w_side.far_zero ? 17'd0 : 17'(w_far));
    assign w_sp   = 26'(w_side.wd) * 26'(w_ssum);

    always_comb begin
        case (r_model)
            MODEL_FLAT, MODEL_RING: w_final = w_side.wbase;
            MODEL_CONCAVE:          w_final = w_side.cblend ? w_cb : w_side.wbase;
            MODEL_SPHERE: begin
                if (w_side.inner)         w_final = ONE_Q15;
                else if (w_side.sph_zero) w_final = '0;
                else                      w_final = w_sp[24:9];
            end
            MODEL_GAUSS: begin
                if (w_side.gcut)          w_final = '0;
                // zero sigma: a spike at the center
                else if (w_side.szero)    w_final = w_side.dz ? ONE_Q15 : 16'd0;
                else                      w_final = w_gw;
            end
            default:                      w_final = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // output buffer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= w_final;
        end
    end

    assign o_valid  = (r_cnt != 2'd0);
    assign o_weight = r_buf[r_rp];

endmodule
